[rtl/htd_pkg.sv]
// shared types and constants for the huffman tree walk decoder
// no dependencies; all other rtl files refer to it by scoped names
package htd_pkg;

  localparam int IDX_W  = 9;
  localparam int SYM_W  = 8;
  localparam int BYTE_W = 8;
  localparam int CNT_W  = 4;

  localparam logic [CNT_W-1:0] BITS_PER_BYTE = CNT_W'(BYTE_W);

  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_DECODE = 1'b1;

  typedef struct packed {
    logic             leaf;
    logic [SYM_W-1:0] symbol;
    logic [IDX_W-1:0] left;
    logic [IDX_W-1:0] right;
  } node_t;

  typedef struct packed {
    logic              func;
    logic [IDX_W-1:0]  node_index;
    node_t             node;
    logic [BYTE_W-1:0] data_byte;
    logic [CNT_W-1:0]  valid_bits;
  } item_t;

  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    node_t            wr_node;
    logic             rd_en;
    logic [IDX_W-1:0] rd_idx;
  } store_req_t;

  typedef struct packed {
    logic             valid;
    logic [SYM_W-1:0] symbol;
    logic             last;
  } push_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] root;
  } cfg_wr_t;

endpackage

[rtl/htd_node_store.sv]
// node store memory: one write port, one registered read port
// depends on htd_pkg; indexes at or above MAX_NODES read as a zero node
module htd_node_store #(
  parameter int MAX_NODES = 512
) (
  input  logic                clk,
  input  htd_pkg::store_req_t req,
  output htd_pkg::node_t      rd_node
);

  localparam int AW = $clog2(MAX_NODES);

  htd_pkg::node_t mem [MAX_NODES];
  htd_pkg::node_t rd_q_r;
  logic           rd_in_r;
  logic           wr_in;
  logic           rd_in;

  assign wr_in = 32'(req.wr_idx) < 32'(MAX_NODES);
  assign rd_in = 32'(req.rd_idx) < 32'(MAX_NODES);

  always_ff @(posedge clk) begin
    if (req.wr_en && wr_in) begin
      mem[req.wr_idx[AW-1:0]] <= req.wr_node;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_q_r  <= mem[req.rd_idx[AW-1:0]];
      rd_in_r <= rd_in;
    end
  end

  assign rd_node = rd_in_r ? rd_q_r : '0;

endmodule

[rtl/htd_walk_seq.sv]
// walk sequencer: steps through code bits, at most one node-store read per step
// depends on htd_pkg; drives the node store and the result push
module htd_walk_seq (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_acc,
  input  htd_pkg::item_t          item,
  input  htd_pkg::cfg_wr_t        cfg,
  input  logic [htd_pkg::IDX_W-1:0] root_idx,
  input  logic                    out_free,
  input  htd_pkg::node_t          rd_node,
  output htd_pkg::store_req_t     store_req,
  output htd_pkg::push_t          push,
  output logic                    idle
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_STEP  = 4'b0010,
    S_FETCH = 4'b0100,
    S_FLUSH = 4'b1000
  } state_t;

  localparam logic [htd_pkg::CNT_W-1:0] CNT_ONE = {{(htd_pkg::CNT_W-1){1'b0}}, 1'b1};

  state_t                         state_r, state_nxt;
  logic [htd_pkg::IDX_W-1:0]      walk_r, walk_nxt;
  htd_pkg::node_t                 cur_r, cur_nxt;
  logic                           cur_ok_r, cur_ok_nxt;
  htd_pkg::node_t                 root_node_r, root_node_nxt;
  logic                           root_ok_r, root_ok_nxt;
  logic [htd_pkg::BYTE_W-1:0]     data_r, data_nxt;
  logic [htd_pkg::CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                           fstep_r, fstep_nxt;
  logic [htd_pkg::SYM_W-1:0]      pend_sym_r, pend_sym_nxt;
  logic                           pend_valid_r, pend_valid_nxt;

  logic                           stall_emit;
  logic                           at_root;
  logic [htd_pkg::IDX_W-1:0]      child;
  logic [htd_pkg::CNT_W-1:0]      sat_cnt;

  assign stall_emit = pend_valid_r && !out_free;
  assign at_root    = (walk_r == root_idx);
  assign sat_cnt    = (item.valid_bits > htd_pkg::BITS_PER_BYTE) ?
                      htd_pkg::BITS_PER_BYTE : item.valid_bits;
  assign idle       = (state_r == S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    walk_nxt       = walk_r;
    cur_nxt        = cur_r;
    cur_ok_nxt     = cur_ok_r;
    root_node_nxt  = root_node_r;
    root_ok_nxt    = root_ok_r;
    data_nxt       = data_r;
    cnt_nxt        = cnt_r;
    fstep_nxt      = fstep_r;
    pend_sym_nxt   = pend_sym_r;
    pend_valid_nxt = pend_valid_r;
    child          = data_r[htd_pkg::BYTE_W-1] ? cur_r.right : cur_r.left;

    store_req         = '0;
    store_req.wr_idx  = item.node_index;
    store_req.wr_node = item.node;
    store_req.rd_idx  = walk_r;
    push              = '0;

    case (state_r)
      S_IDLE: begin
        if (cfg.we) begin
          walk_nxt    = cfg.root;
          cur_ok_nxt  = 1'b0;
          root_ok_nxt = 1'b0;
        end else if (in_acc) begin
          if (item.func == htd_pkg::FUNC_LOAD) begin
            store_req.wr_en = 1'b1;
            walk_nxt        = root_idx;
            cur_ok_nxt      = 1'b0;
            root_ok_nxt     = 1'b0;
          end else begin
            data_nxt = item.data_byte;
            cnt_nxt  = sat_cnt;
            if (sat_cnt != '0) begin
              state_nxt = S_STEP;
            end
          end
        end
      end
      S_STEP: begin
        if (!cur_ok_r) begin
          // refill the current node, no bit used
          store_req.rd_en = 1'b1;
          fstep_nxt       = 1'b0;
          state_nxt       = S_FETCH;
        end else if (cur_r.leaf) begin
          // leaf root: emit it once per bit
          if (!stall_emit) begin
            push.valid     = pend_valid_r;
            push.symbol    = pend_sym_r;
            pend_sym_nxt   = cur_r.symbol;
            pend_valid_nxt = 1'b1;
            walk_nxt       = root_idx;
            cur_nxt        = root_node_r;
            cur_ok_nxt     = root_ok_r;
            data_nxt       = {data_r[htd_pkg::BYTE_W-2:0], 1'b0};
            cnt_nxt        = cnt_r - CNT_ONE;
            state_nxt      = (cnt_r == CNT_ONE) ? S_FLUSH : S_STEP;
          end
        end else begin
          store_req.rd_en  = 1'b1;
          store_req.rd_idx = child;
          walk_nxt         = child;
          data_nxt         = {data_r[htd_pkg::BYTE_W-2:0], 1'b0};
          cnt_nxt          = cnt_r - CNT_ONE;
          fstep_nxt        = 1'b1;
          state_nxt        = S_FETCH;
        end
      end
      S_FETCH: begin
        child = data_r[htd_pkg::BYTE_W-1] ? rd_node.right : rd_node.left;
        if (at_root) begin
          root_node_nxt = rd_node;
          root_ok_nxt   = 1'b1;
        end
        if (!fstep_r) begin
          cur_nxt    = rd_node;
          cur_ok_nxt = 1'b1;
          state_nxt  = S_STEP;
        end else if (rd_node.leaf) begin
          if (!stall_emit) begin
            push.valid     = pend_valid_r;
            push.symbol    = pend_sym_r;
            pend_sym_nxt   = rd_node.symbol;
            pend_valid_nxt = 1'b1;
            walk_nxt       = root_idx;
            cur_nxt        = at_root ? rd_node : root_node_r;
            cur_ok_nxt     = at_root || root_ok_r;
            state_nxt      = (cnt_r == '0) ? S_FLUSH : S_STEP;
          end
        end else if (cnt_r == '0) begin
          cur_nxt    = rd_node;
          cur_ok_nxt = 1'b1;
          state_nxt  = S_FLUSH;
        end else begin
          // chain straight into the next step
          store_req.rd_en  = 1'b1;
          store_req.rd_idx = child;
          walk_nxt         = child;
          cur_ok_nxt       = 1'b0;
          data_nxt         = {data_r[htd_pkg::BYTE_W-2:0], 1'b0};
          cnt_nxt          = cnt_r - CNT_ONE;
        end
      end
      S_FLUSH: begin
        if (!pend_valid_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          push.valid     = 1'b1;
          push.symbol    = pend_sym_r;
          push.last      = 1'b1;
          pend_valid_nxt = 1'b0;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      walk_r       <= '0;
      cur_ok_r     <= 1'b0;
      root_ok_r    <= 1'b0;
      pend_valid_r <= 1'b0;
      fstep_r      <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      walk_r       <= walk_nxt;
      cur_ok_r     <= cur_ok_nxt;
      root_ok_r    <= root_ok_nxt;
      pend_valid_r <= pend_valid_nxt;
      fstep_r      <= fstep_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r       <= cur_nxt;
    root_node_r <= root_node_nxt;
    data_r      <= data_nxt;
    cnt_r       <= cnt_nxt;
    pend_sym_r  <= pend_sym_nxt;
  end

endmodule

[rtl/huffman_tree_walk_decoder_top.sv]
// walk: after the accept a byte runs a start step, then a node-store read per code bit, an
//   extra step for each symbol followed by further bits, a root refetch after a node
//   load or root write, and a flush step; a leaf root emits once per bit, then flushes
// throughput: one item at a time; a load item does not hold the input; a byte with code
//   bits holds the input stalled for its walk and flush, longer under output stalls
// reset: rst_n synchronous, active low; walk and root index go to 0, store is not cleared
module huffman_tree_walk_decoder_top #(
  parameter int MAX_NODES = 512
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input item channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_func,
  input  logic [htd_pkg::IDX_W-1:0]     in_node_index,
  input  logic                          in_node_is_leaf,
  input  logic [htd_pkg::SYM_W-1:0]     in_node_symbol,
  input  logic [htd_pkg::IDX_W-1:0]     in_node_left,
  input  logic [htd_pkg::IDX_W-1:0]     in_node_right,
  input  logic [htd_pkg::BYTE_W-1:0]    in_data_byte,
  input  logic [htd_pkg::CNT_W-1:0]     in_valid_bits,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [htd_pkg::SYM_W-1:0]     out_symbol,
  output logic                          out_last,
  // root index register write
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [htd_pkg::IDX_W-1:0]     cfg_data
);

  logic [htd_pkg::IDX_W-1:0] root_r;
  logic                      out_valid_r;
  logic [htd_pkg::SYM_W-1:0] out_symbol_r;
  logic                      out_last_r;

  logic                      seq_idle;
  logic                      in_acc;
  logic                      out_free;
  htd_pkg::item_t            item;
  htd_pkg::cfg_wr_t          cfg;
  htd_pkg::store_req_t       store_req;
  htd_pkg::node_t            rd_node;
  htd_pkg::push_t            push;

  // items are taken only while the sequencer is idle
  assign in_stall  = !seq_idle;
  assign in_acc    = in_valid && !in_stall;
  // a root write waits until no input transfer is offered
  assign cfg_ready = seq_idle && !in_valid;

  assign cfg.we   = cfg_valid && cfg_ready;
  assign cfg.root = cfg_data;

  assign item.func             = in_func;
  assign item.node_index       = in_node_index;
  assign item.node.leaf        = in_node_is_leaf;
  assign item.node.symbol      = in_node_symbol;
  assign item.node.left        = in_node_left;
  assign item.node.right       = in_node_right;
  assign item.data_byte        = in_data_byte;
  assign item.valid_bits       = in_valid_bits;

  // output slot is free when empty or its transfer completes this cycle
  assign out_free = !out_valid_r || !out_stall;

  // root index register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_r <= '0;
    end else if (cfg.we) begin
      root_r <= cfg_data;
    end
  end

  // result register, parts the sequencer from the downstream stall
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push.valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      out_symbol_r <= push.symbol;
      out_last_r   <= push.last;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_symbol = out_symbol_r;
  assign out_last   = out_last_r;

  htd_node_store #(
    .MAX_NODES (MAX_NODES)
  ) u_store (
    .clk     (clk),
    .req     (store_req),
    .rd_node (rd_node)
  );

  htd_walk_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_acc    (in_acc),
    .item      (item),
    .cfg       (cfg),
    .root_idx  (root_r),
    .out_free  (out_free),
    .rd_node   (rd_node),
    .store_req (store_req),
    .push      (push),
    .idle      (seq_idle)
  );

endmodule

[rtl/htd_checker.sv]
// port-level checks for the huffman tree walk decoder
// depends on htd_pkg widths; bound to huffman_tree_walk_decoder_top below
module htd_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       in_func,
  input logic [htd_pkg::CNT_W-1:0]  in_valid_bits,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [htd_pkg::SYM_W-1:0]  out_symbol,
  input logic                       out_last
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_symbol) && $stable(out_last))
    else $error("result payload changed while stalled");

  // a node load finishes in its accept cycle
  a_load_quick: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_func == htd_pkg::FUNC_LOAD) |=> !in_stall)
    else $error("node load held the input");

  // a byte with code bits sets the input stall after its accept
  a_decode_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_func == htd_pkg::FUNC_DECODE) && (in_valid_bits != '0)
    |=> in_stall)
    else $error("decode transfer did not start a walk");

endmodule

bind huffman_tree_walk_decoder_top htd_checker u_htd_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .in_func       (in_func),
  .in_valid_bits (in_valid_bits),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_symbol    (out_symbol),
  .out_last      (out_last)
);
